// ===== src/tauc_pkg.sv =====
package tauc_pkg;

    localparam int unsigned TICK_W      = 16;
    localparam int unsigned ACC_W       = 40;
    localparam int unsigned SECS_W      = 28;
    localparam int unsigned DAYS_W      = 12;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned MIN_W       = 6;
    localparam int unsigned SEC_W       = 6;
    localparam int unsigned FRAC_BITS_DEF = 12;

    localparam int unsigned OUT_W       = SECS_W + DAYS_W + HOUR_W + MIN_W + SEC_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // seconds to minutes: q = (n * ceil(2^34 / 60)) >> 34, exact for n < 2^28
    localparam int unsigned Q1_W        = 23;
    localparam int unsigned RECIP1      = 286331154;
    localparam int unsigned RECIP1_W    = 29;
    localparam int unsigned SHIFT1      = 34;

    // minutes to hours: exact for n < 2^23
    localparam int unsigned Q2_W        = 17;
    localparam int unsigned RECIP2      = 8947849;
    localparam int unsigned RECIP2_W    = 24;
    localparam int unsigned SHIFT2      = 29;

    // hours to days: exact for n < 2^17
    localparam int unsigned RECIP3      = 174763;
    localparam int unsigned RECIP3_W    = 18;
    localparam int unsigned SHIFT3      = 22;

    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned MinsPerHour = 60;
    localparam int unsigned HoursPerDay = 24;

endpackage

// ===== src/tauc_accum.sv =====
module tauc_accum
    import tauc_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [TICK_W-1:0] i_ticks,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [SECS_W-1:0] o_secs
);

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic              r_dither;
    logic              r_vld;
    logic [SECS_W-1:0] r_secs;
    logic [TICK_W-1:0] ticks_dith;
    logic [ACC_W-1:0]  acc_shr;
    logic              take;

    assign o_rdy      = !r_vld || i_rdy;
    assign take       = i_vld && o_rdy;
    assign ticks_dith = i_ticks + TICK_W'(r_dither);
    assign n_acc      = r_acc + ACC_W'(ticks_dith);
    assign acc_shr    = n_acc >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_dither <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            if (take) begin
                r_acc    <= n_acc;
                r_dither <= !r_dither;
                r_vld    <= 1'b1;
            end else if (i_rdy) begin
                r_vld    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_secs <= acc_shr[SECS_W-1:0];
        end
    end

    assign o_vld  = r_vld;
    assign o_secs = r_secs;

`ifndef ASSERT_OFF
    a_dither_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_dither != $past(r_dither)))
        else $error("dither bit did not flip on request");

    a_acc_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_acc) && $stable(r_dither))
        else $error("accumulator changed without request");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_rdy) |=> r_vld && $stable(r_secs))
        else $error("seconds changed while stalled");
`endif

endmodule

// ===== src/tauc_divstage.sv =====
module tauc_divstage
    import tauc_pkg::*;
#(
    parameter int unsigned IN_W    = 28,
    parameter int unsigned Q_W     = 23,
    parameter int unsigned R_W     = 6,
    parameter int unsigned SIDE_W  = 28,
    parameter int unsigned DIVISOR = 60,
    parameter int unsigned RECIP   = 286331154,
    parameter int unsigned RECIP_W = 29,
    parameter int unsigned SHIFT   = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [IN_W-1:0]   i_num,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [Q_W-1:0]    o_quo,
    output logic [R_W-1:0]    o_rem,
    output logic [SIDE_W-1:0] o_side
);

    localparam int unsigned PROD_W = IN_W + RECIP_W;

    logic              r_p_vld;
    logic [PROD_W-1:0] r_prod;
    logic [IN_W-1:0]   r_num;
    logic [SIDE_W-1:0] r_p_side;
    logic              r_q_vld;
    logic [Q_W-1:0]    r_quo;
    logic [R_W-1:0]    r_rem;
    logic [SIDE_W-1:0] r_q_side;
    logic              p_rdy;
    logic              q_rdy;
    logic [Q_W-1:0]    quo;
    logic [IN_W-1:0]   rem_full;

    assign q_rdy    = !r_q_vld || i_rdy;
    assign p_rdy    = !r_p_vld || q_rdy;
    assign o_rdy    = p_rdy;
    assign quo      = r_prod[SHIFT +: Q_W];
    assign rem_full = r_num - IN_W'(IN_W'(quo) * IN_W'(DIVISOR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_q_vld <= 1'b0;
        end else begin
            if (p_rdy) begin
                r_p_vld <= i_vld;
            end
            if (q_rdy) begin
                r_q_vld <= r_p_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_rdy && i_vld) begin
            r_prod   <= PROD_W'(i_num) * PROD_W'(RECIP_W'(RECIP));
            r_num    <= i_num;
            r_p_side <= i_side;
        end
        if (q_rdy && r_p_vld) begin
            r_quo    <= quo;
            r_rem    <= rem_full[R_W-1:0];
            r_q_side <= r_p_side;
        end
    end

    assign o_vld  = r_q_vld;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_side = r_q_side;

`ifndef ASSERT_OFF
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_rdy && r_p_vld) |-> (rem_full < IN_W'(DIVISOR)))
        else $error("remainder not below divisor");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_p_vld && !r_q_vld)
        else $error("pipeline not empty after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_vld && !i_rdy) |=> r_q_vld && $stable(r_quo) && $stable(r_rem)
            && $stable(r_q_side))
        else $error("stage output changed while stalled");
`endif

endmodule

// ===== src/tick_accumulating_uptime_clock.sv =====
// channel  | dir | tdata fields (lsb first)                                      | tlast/tuser
// s_axis   | in  | tick_count[15:0]                                              | none
// m_axis   | out | total_secs[27:0] days[39:28] hour[44:40] min[50:45] sec[56:51] | none
//
// one request accepted per cycle while m_axis_tready does not stall the pipeline
// a result passes through the accumulator register and three multiply/remainder pairs
// synchronous active-low reset clears the accumulator, dither bit and all valids
// each pipeline register advances when empty or when the stage after it moves,
// so bubbles close up and a stalled output still lets earlier stages fill
module tick_accumulating_uptime_clock
    import tauc_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TICK_W-1:0]      s_axis_tdata,   // tick_count
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // total_secs, days, hour, min, sec
);

    localparam int unsigned SIDE2_W = SECS_W + SEC_W;
    localparam int unsigned SIDE3_W = SIDE2_W + MIN_W;

    logic                a_vld;
    logic                a_rdy;
    logic [SECS_W-1:0]   a_secs;

    logic                d1_vld;
    logic                d1_rdy;
    logic [Q1_W-1:0]     d1_quo;
    logic [SEC_W-1:0]    d1_rem;
    logic [SECS_W-1:0]   d1_side;

    logic                d2_vld;
    logic                d2_rdy;
    logic [Q2_W-1:0]     d2_quo;
    logic [MIN_W-1:0]    d2_rem;
    logic [SIDE2_W-1:0]  d2_side;

    logic [DAYS_W-1:0]   d3_quo;
    logic [HOUR_W-1:0]   d3_rem;
    logic [SIDE3_W-1:0]  d3_side;

    tauc_accum #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_ticks (s_axis_tdata),
        .o_vld   (a_vld),
        .i_rdy   (a_rdy),
        .o_secs  (a_secs)
    );

    tauc_divstage #(
        .IN_W    (SECS_W),
        .Q_W     (Q1_W),
        .R_W     (SEC_W),
        .SIDE_W  (SECS_W),
        .DIVISOR (SecsPerMin),
        .RECIP   (RECIP1),
        .RECIP_W (RECIP1_W),
        .SHIFT   (SHIFT1)
    ) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (a_vld),
        .o_rdy   (a_rdy),
        .i_num   (a_secs),
        .i_side  (a_secs),
        .o_vld   (d1_vld),
        .i_rdy   (d1_rdy),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_side  (d1_side)
    );

    tauc_divstage #(
        .IN_W    (Q1_W),
        .Q_W     (Q2_W),
        .R_W     (MIN_W),
        .SIDE_W  (SIDE2_W),
        .DIVISOR (MinsPerHour),
        .RECIP   (RECIP2),
        .RECIP_W (RECIP2_W),
        .SHIFT   (SHIFT2)
    ) u_div_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d1_vld),
        .o_rdy   (d1_rdy),
        .i_num   (d1_quo),
        .i_side  ({d1_rem, d1_side}),
        .o_vld   (d2_vld),
        .i_rdy   (d2_rdy),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    tauc_divstage #(
        .IN_W    (Q2_W),
        .Q_W     (DAYS_W),
        .R_W     (HOUR_W),
        .SIDE_W  (SIDE3_W),
        .DIVISOR (HoursPerDay),
        .RECIP   (RECIP3),
        .RECIP_W (RECIP3_W),
        .SHIFT   (SHIFT3)
    ) u_div_day (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d2_vld),
        .o_rdy   (d2_rdy),
        .i_num   (d2_quo),
        .i_side  ({d2_rem, d2_side}),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_quo   (d3_quo),
        .o_rem   (d3_rem),
        .o_side  (d3_side)
    );

    // d3_side holds {min, sec, total_secs}
    assign m_axis_tdata = OUT_TDATA_W'({d3_side[SECS_W +: SEC_W],
                                        d3_side[SIDE3_W-1 -: MIN_W],
                                        d3_rem,
                                        d3_quo,
                                        d3_side[SECS_W-1:0]});

endmodule
